// ===== rtl/kmer_histogram_counter_core_assert.svh =====
// Assertion macros shared by the k-mer histogram counter RTL.
`ifndef KMER_HISTOGRAM_COUNTER_CORE_ASSERT_SVH
`define KMER_HISTOGRAM_COUNTER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define KHC_ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("khc: assertion failed");
`define KHC_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("khc: assertion failed");
`else
`define KHC_ASSERT_IMPLIES(lbl, clk, rst, pre, post)
`define KHC_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// ===== rtl/khc_pkg.sv =====
// Types, constants and helpers shared by the k-mer histogram counter.
`default_nettype none
package khc_pkg;

  localparam int WEIGHT_BITS     = 24;
  localparam int READ_INDEX_BITS = 18;
  localparam int OUT_COUNT_BITS  = 32;
  localparam int KLEN_BITS       = 4;
  localparam int PADDR_BITS      = 3;
  localparam int PDATA_BITS      = 32;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [7:0] CHAR_NL   = 8'h0a;
  localparam logic [7:0] CHAR_UC_C = 8'h43;
  localparam logic [7:0] CHAR_UC_G = 8'h47;
  localparam logic [7:0] CHAR_UC_T = 8'h54;
  localparam logic [7:0] CHAR_LC_C = 8'h63;
  localparam logic [7:0] CHAR_LC_G = 8'h67;
  localparam logic [7:0] CHAR_LC_T = 8'h74;

  localparam logic REG_KMER_LENGTH = 1'b0;
  localparam logic REG_WEIGHT_MODE = 1'b1;

  typedef enum logic [1:0] {
    CMD_SEQ    = 2'd0,
    CMD_HEADER = 2'd1,
    CMD_READ   = 2'd2
  } khc_cmd_t;

  typedef struct packed {
    khc_cmd_t                   cmd;
    logic [7:0]                 seq_byte;
    logic [WEIGHT_BITS-1:0]     multiplicity;
    logic [READ_INDEX_BITS-1:0] read_index;
  } khc_in_t;

  typedef struct packed {
    logic [OUT_COUNT_BITS-1:0] count_value;
    logic                      count_saturated;
  } khc_out_t;

  typedef struct packed {
    logic [KLEN_BITS-1:0] kmer_length;
    logic                 weight_mode;
    logic                 length_write;
  } khc_cfg_t;

  function automatic logic [1:0] base_code(input logic [7:0] ch);
    logic [1:0] code;
    case (ch)
      CHAR_UC_C, CHAR_LC_C: code = 2'd1;
      CHAR_UC_G, CHAR_LC_G: code = 2'd2;
      CHAR_UC_T, CHAR_LC_T: code = 2'd3;
      default:              code = 2'd0;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/khc_front.sv =====
// Front end: takes beats, tracks the base window, emits count and read ops.
`default_nettype none
`include "kmer_histogram_counter_core_assert.svh"
module khc_front import khc_pkg::*; #(
  parameter int MAX_K       = 9,
  parameter int TABLE_DEPTH = 262144
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  khc_cfg_t                               cfg,
  input  logic                                   clearing,
  input  logic                                   item_valid,
  output logic                                   item_ready,
  input  khc_in_t                                item,
  output logic                                   op_valid,
  output logic [$clog2(TABLE_DEPTH)+WEIGHT_BITS:0] op,
  input  logic                                   op_full
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int KW = $clog2(MAX_K + 1);
  localparam int VW = (2 * MAX_K > READ_INDEX_BITS) ? 2 * MAX_K : READ_INDEX_BITS;
  localparam int S  = VW + IW;
  localparam int MW = VW + 1;
  localparam int DW = IW + 1;
  localparam int EW = S + VW;
  localparam int RW = ((VW > IW) ? VW : IW) + 1;
  localparam longint unsigned RECIP = (64'd1 << S) / TABLE_DEPTH;
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

  logic [MAX_K-1:0][1:0]  window;
  logic [MAX_K-1:0][1:0]  shifted;
  logic [MAX_K-1:0][1:0]  win_next;
  logic [KW-1:0]          nbases;
  logic [KW-1:0]          nb_next;
  logic [WEIGHT_BITS-1:0] weight;
  logic [KLEN_BITS-1:0]   keff;
  logic [1:0]             code;
  logic                   complete;
  logic                   adv;
  logic                   accept;
  logic                   emit;
  logic                   emit_read;
  logic [VW-1:0]          emit_v;
  logic [WEIGHT_BITS-1:0] emit_inc;

  logic                   a_valid, b_valid, c_valid;
  logic                   a_read, b_read, c_read;
  logic [WEIGHT_BITS-1:0] a_inc, b_inc, c_inc;
  logic [VW-1:0]          a_v, b_v, c_v;
  logic [VW-1:0]          b_q;
  logic [VW-1:0]          c_qd;
  logic [VW+MW-1:0]       prod;
  logic [EW-1:0]          prod_ext;
  logic [VW+DW-1:0]       qd_full;
  logic [VW-1:0]          rem;
  logic [RW-1:0]          rem_ext;
  logic [RW-1:0]          wrapped;

  always_comb begin
    keff = cfg.kmer_length;
    if (cfg.kmer_length == '0) begin
      keff = KLEN_BITS'(1);
    end else if (cfg.kmer_length > KLEN_BITS'(MAX_K)) begin
      keff = KLEN_BITS'(MAX_K);
    end
    code    = base_code(item.seq_byte);
    shifted = window >> 2;
    for (int b = 0; b < MAX_K; b++) begin
      if (b + 1 < int'(keff)) begin
        win_next[b] = shifted[b];
      end else if (b + 1 == int'(keff)) begin
        win_next[b] = code;
      end else begin
        win_next[b] = 2'd0;
      end
    end
    nb_next  = (KLEN_BITS'(nbases) < keff) ? nbases + 1'b1 : nbases;
    complete = KLEN_BITS'(nb_next) >= keff;
  end

  always_comb begin
    emit      = 1'b0;
    emit_read = 1'b0;
    emit_v    = VW'(win_next);
    emit_inc  = cfg.weight_mode ? weight : WEIGHT_BITS'(1);
    case (item.cmd)
      CMD_SEQ: begin
        emit = (item.seq_byte != CHAR_NL) && complete;
      end
      CMD_READ: begin
        emit      = 1'b1;
        emit_read = 1'b1;
        emit_v    = VW'(item.read_index);
      end
      default: begin
      end
    endcase
  end

  assign adv        = !c_valid || !op_full;
  assign item_ready = adv && !clearing;
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      nbases <= '0;
      weight <= WEIGHT_BITS'(1);
    end else if (cfg.length_write) begin
      window <= '0;
      nbases <= '0;
    end else if (accept) begin
      case (item.cmd)
        CMD_SEQ: begin
          if (item.seq_byte == CHAR_NL) begin
            window <= '0;
            nbases <= '0;
          end else begin
            window <= win_next;
            nbases <= nb_next;
          end
        end
        CMD_HEADER: begin
          window <= '0;
          nbases <= '0;
          if (cfg.weight_mode) begin
            weight <= item.multiplicity;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // index wrap: v mod TABLE_DEPTH by reciprocal multiply and one correction
  assign prod     = a_v * RECIP_M;
  assign prod_ext = EW'(prod);
  assign qd_full  = b_q * DW'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= accept && emit;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_read <= emit_read;
      a_inc  <= emit_inc;
      a_v    <= emit_v;
      b_read <= a_read;
      b_inc  <= a_inc;
      b_v    <= a_v;
      b_q    <= prod_ext[S +: VW];
      c_read <= b_read;
      c_inc  <= b_inc;
      c_v    <= b_v;
      c_qd   <= VW'(qd_full);
    end
  end

  assign rem     = c_v - c_qd;
  assign rem_ext = RW'(rem);
  assign wrapped = (rem_ext >= RW'(TABLE_DEPTH)) ? rem_ext - RW'(TABLE_DEPTH) : rem_ext;

  assign op_valid = c_valid && !op_full;
  assign op       = {c_read, c_inc, IW'(wrapped)};

  `KHC_ASSERT_IMPLIES(a_bases_bound, clk, rst, 1'b1, KLEN_BITS'(nbases) <= keff)
  `KHC_ASSERT_NEXT(a_stall_hold, clk, rst, c_valid && op_full, c_valid && $stable(c_v))

endmodule
`default_nettype wire

// ===== rtl/khc_queue.sv =====
// Small op queue between the front end and the count store.
`default_nettype none
module khc_queue import khc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == (AW + 1)'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/khc_back.sv =====
// Back end: count store with read-modify-write, forwarding and result register.
`default_nettype none
`include "kmer_histogram_counter_core_assert.svh"
module khc_back import khc_pkg::*; #(
  parameter int TABLE_DEPTH = 262144,
  parameter int COUNT_BITS  = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   op_empty,
  input  logic [$clog2(TABLE_DEPTH)+WEIGHT_BITS:0] op,
  output logic                                   op_pop,
  output logic                                   clearing,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output khc_out_t                               result
);

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int OPW = IW + WEIGHT_BITS + 1;
  localparam int SW  = ((COUNT_BITS > WEIGHT_BITS) ? COUNT_BITS : WEIGHT_BITS) + 1;
  localparam int XW  = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [COUNT_BITS-1:0]  mem [TABLE_DEPTH];
  logic [COUNT_BITS-1:0]  rdata;

  logic                   h_read;
  logic [WEIGHT_BITS-1:0] h_inc;
  logic [IW-1:0]          h_idx;

  logic                   x_valid;
  logic                   x_read;
  logic [WEIGHT_BITS-1:0] x_inc;
  logic [IW-1:0]          x_idx;
  logic                   x_adv;
  logic                   out_load;

  logic                   fwd_valid;
  logic [IW-1:0]          fwd_idx;
  logic [COUNT_BITS-1:0]  fwd_val;

  logic [COUNT_BITS-1:0]  cur;
  logic [SW-1:0]          sum;
  logic [COUNT_BITS-1:0]  new_count;
  logic [XW-1:0]          cur_ext;

  logic [IW-1:0]          clr_addr;
  logic                   we;
  logic [IW-1:0]          waddr;
  logic [COUNT_BITS-1:0]  wdata;

  assign h_read = op[OPW-1];
  assign h_inc  = op[OPW-2 -: WEIGHT_BITS];
  assign h_idx  = op[IW-1:0];

  assign out_load = x_valid && x_read && (!result_valid || result_ready);
  assign x_adv    = !x_valid || !x_read || out_load;
  assign op_pop   = !op_empty && x_adv && !clearing;

  // the write at the edge of this op's read is not seen by the memory read
  assign cur       = (fwd_valid && fwd_idx == x_idx) ? fwd_val : rdata;
  assign sum       = SW'(cur) + SW'(x_inc);
  assign new_count = (sum > SW'(CMAX)) ? CMAX : COUNT_BITS'(sum);
  assign cur_ext   = XW'(cur);

  assign we    = clearing || (x_valid && !x_read);
  assign waddr = clearing ? clr_addr : x_idx;
  assign wdata = clearing ? '0 : new_count;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (op_pop) begin
      rdata <= mem[h_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IW'(TABLE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid   <= 1'b0;
      fwd_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (x_adv) begin
        x_valid <= op_pop;
      end
      if (x_valid && !x_read) begin
        fwd_valid <= 1'b1;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      x_read <= h_read;
      x_inc  <= h_inc;
      x_idx  <= h_idx;
    end
    if (x_valid && !x_read) begin
      fwd_idx <= x_idx;
      fwd_val <= new_count;
    end
    if (out_load) begin
      result.count_value     <= cur_ext[OUT_COUNT_BITS-1:0];
      result.count_saturated <= cur == CMAX;
    end
  end

  `KHC_ASSERT_IMPLIES(a_clear_quiet, clk, rst, clearing, !x_valid && !result_valid)
  `KHC_ASSERT_IMPLIES(a_count_monotone, clk, rst, x_valid && !x_read, new_count >= cur)
  `KHC_ASSERT_NEXT(a_read_waits, clk, rst, x_valid && x_read && !out_load, x_valid && x_read && $stable(x_idx))

endmodule
`default_nettype wire

// ===== rtl/kmer_histogram_counter_core.sv =====
// Top level of the k-mer histogram counter: register port and block wiring.
`default_nettype none
// Counts k-mers of 1..MAX_K bases in a nucleotide byte stream into a table of
// TABLE_DEPTH saturating counters of COUNT_BITS bits. Items are taken one per
// cycle while the op queue has room and no clear runs: a front end tracks the
// base window and wraps table indices over a three-stage pipeline, a four-entry
// queue decouples it from the count store, whose single read port and single
// write port do one read-modify-write per cycle unless a read waits on the
// output register, with forwarding of the previous write. A read command's
// count is held in an output register until taken. After reset the count
// store is cleared one entry per cycle, all TABLE_DEPTH entries (262144 by
// default), while item_ready stays low; register writes are taken throughout.
// Registers: kmer_length at byte address 0, weight_mode at byte address 4.
module kmer_histogram_counter_core import khc_pkg::*; #(
  parameter int MAX_K       = 9,
  parameter int TABLE_DEPTH = 262144,
  parameter int COUNT_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  khc_in_t               item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output khc_out_t              result
);

  localparam int OPW = $clog2(TABLE_DEPTH) + WEIGHT_BITS + 1;

  logic [KLEN_BITS-1:0] kmer_length;
  logic                 weight_mode;
  logic                 reg_write;
  logic                 reg_index;
  khc_cfg_t             cfg;

  logic                 clearing;
  logic                 op_valid;
  logic [OPW-1:0]       op_in;
  logic [OPW-1:0]       op_head;
  logic                 op_full;
  logic                 op_empty;
  logic                 op_pop;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= KLEN_BITS'(1);
      weight_mode <= 1'b0;
    end else if (reg_write) begin
      case (reg_index)
        REG_KMER_LENGTH: kmer_length <= pwdata[KLEN_BITS-1:0];
        REG_WEIGHT_MODE: weight_mode <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_KMER_LENGTH: prdata = PDATA_BITS'(kmer_length);
      REG_WEIGHT_MODE: prdata = PDATA_BITS'(weight_mode);
      default:         prdata = '0;
    endcase
  end

  assign cfg.kmer_length  = kmer_length;
  assign cfg.weight_mode  = weight_mode;
  assign cfg.length_write = reg_write && (reg_index == REG_KMER_LENGTH);

  khc_front #(
    .MAX_K       (MAX_K),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .clearing   (clearing),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .op_valid   (op_valid),
    .op         (op_in),
    .op_full    (op_full)
  );

  khc_queue #(
    .WIDTH (OPW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (op_valid),
    .push_data (op_in),
    .pop       (op_pop),
    .head      (op_head),
    .full      (op_full),
    .empty     (op_empty)
  );

  khc_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .op_empty     (op_empty),
    .op           (op_head),
    .op_pop       (op_pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire
